### hdl/chgcal_pkg.sv
// ----------------------------------------------------------------------------
// chgcal_pkg: shared types and constants for the charger detect block
// Item and result layouts, config registers, state codes and the constant
// dividers used by the calibration filter.
// ----------------------------------------------------------------------------
package chgcal_pkg;

  // field widths
  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int VOLT_BITS   = 12;
  localparam int OP_BITS     = 2;
  localparam int CNT_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // accumulator and filter sum widths
  localparam int ACC_BITS = SAMPLE_BITS + FRAC_BITS + 7;
  localparam int SUM_BITS = ACC_BITS + 1;
  localparam int OFS_BITS = ACC_BITS - FRAC_BITS;

  localparam logic [CNT_BITS-1:0]    CNT_MAX    = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // reciprocal for floor(a / 100), exact for every a below 2^SUM_BITS
  localparam int Q100_BITS     = SUM_BITS - 6;
  localparam int DIV100_SHIFT  = SUM_BITS + 7;
  localparam longint unsigned DIV100_RECIP =
    ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;
  localparam logic [SUM_BITS:0] DIV100_MUL = DIV100_RECIP[SUM_BITS:0];

  // reciprocal for floor(x / 99), exact for every x below 2^OFS_BITS
  localparam int Q99_BITS     = OFS_BITS - 6;
  localparam int DIV99_SHIFT  = OFS_BITS + 7;
  localparam longint unsigned DIV99_RECIP =
    ((64'd1 << DIV99_SHIFT) + 64'd98) / 64'd99;
  localparam logic [OFS_BITS:0] DIV99_MUL = DIV99_RECIP[OFS_BITS:0];

  // config register reset values
  localparam logic [VOLT_BITS-1:0] THRESHOLD_RST = 12'd2048;
  localparam logic [CNT_BITS-1:0]  PERIOD_RST    = 16'd10;
  localparam logic [CNT_BITS-1:0]  SETTLE_RST    = 16'd1000;
  localparam logic [CNT_BITS-1:0]  CALIB_RST     = 16'd5000;
  localparam logic [CNT_BITS-1:0]  DEBOUNCE_RST  = 16'd500;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_SETTLE    = 3'd2,
    CFG_CALIB     = 3'd3,
    CFG_DEBOUNCE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_INIT     = 3'd0,
    PH_WAIT_GOV = 3'd1,
    PH_CALIB    = 3'd2,
    PH_WAIT_CHG = 3'd3,
    PH_WAIT_ACK = 3'd4,
    PH_CHARGING = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_DET  = 2'd1,
    MODE_ACK  = 2'd2
  } mode_e;

  typedef enum logic [OP_BITS-1:0] {
    OP_TICK     = 2'd0,
    OP_ACK      = 2'd1,
    OP_WITHDRAW = 2'd2
  } op_e;

  typedef struct packed {
    logic [VOLT_BITS-1:0] threshold;
    logic [CNT_BITS-1:0]  period;
    logic [CNT_BITS-1:0]  settle;
    logic [CNT_BITS-1:0]  calib;
    logic [CNT_BITS-1:0]  debounce;
  } cfg_t;

  typedef struct packed {
    logic                   calibrate_request;
    logic [VOLT_BITS-1:0]   charge_voltage;
    logic [SAMPLE_BITS-1:0] current_raw;
    logic [OP_BITS-1:0]     operation;
  } item_t;

  typedef struct packed {
    logic                   charger_enable;
    logic [2:0]             phase;
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] current_offset;
    logic                   governor_init_pulse;
  } res_t;

  // saturating counter increment
  function automatic logic [CNT_BITS-1:0] sat_inc(logic [CNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // floor(a / 100) by multiply with reciprocal
  function automatic logic [Q100_BITS-1:0] div100(logic [SUM_BITS-1:0] a);
    logic [2*SUM_BITS:0] prod;
    prod = {{(SUM_BITS+1){1'b0}}, a} * {{SUM_BITS{1'b0}}, DIV100_MUL};
    return prod[2*SUM_BITS:DIV100_SHIFT];
  endfunction

  // floor(x / 99) by multiply with reciprocal
  function automatic logic [Q99_BITS-1:0] div99(logic [OFS_BITS-1:0] x);
    logic [2*OFS_BITS:0] prod;
    prod = {{(OFS_BITS+1){1'b0}}, x} * {{OFS_BITS{1'b0}}, DIV99_MUL};
    return prod[2*OFS_BITS:DIV99_SHIFT];
  endfunction

endpackage

### hdl/chgcal_cfg.sv
// ----------------------------------------------------------------------------
// chgcal_cfg: configuration registers
// Holds threshold and timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module chgcal_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [chgcal_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [chgcal_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output chgcal_pkg::cfg_t                      cfg_o
);
  import chgcal_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown index ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: cfg_d.threshold = cfg_wdata_i[VOLT_BITS-1:0];
        CFG_PERIOD:    cfg_d.period    = cfg_wdata_i[CNT_BITS-1:0];
        CFG_SETTLE:    cfg_d.settle    = cfg_wdata_i[CNT_BITS-1:0];
        CFG_CALIB:     cfg_d.calib     = cfg_wdata_i[CNT_BITS-1:0];
        CFG_DEBOUNCE:  cfg_d.debounce  = cfg_wdata_i[CNT_BITS-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RST;
      cfg_q.period    <= PERIOD_RST;
      cfg_q.settle    <= SETTLE_RST;
      cfg_q.calib     <= CALIB_RST;
      cfg_q.debounce  <= DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/chgcal_filter.sv
// ----------------------------------------------------------------------------
// chgcal_filter: calibration filter datapath
// One leaky filter step on the accumulator and the saturated offset
// derived from the current accumulator.
// ----------------------------------------------------------------------------
module chgcal_filter (
  input  logic [chgcal_pkg::ACC_BITS-1:0]    acc_i,
  input  logic [chgcal_pkg::SAMPLE_BITS-1:0] raw_i,
  output logic [chgcal_pkg::ACC_BITS-1:0]    acc_next_o,
  output logic [chgcal_pkg::SAMPLE_BITS-1:0] offset_o
);
  import chgcal_pkg::*;

  logic [SUM_BITS-1:0]  sum;
  logic [Q100_BITS-1:0] leak;
  logic [SUM_BITS-1:0]  diff;
  logic [Q99_BITS-1:0]  quot;

  // acc + raw, then remove one hundredth
  assign sum  = {1'b0, acc_i} + (SUM_BITS'(raw_i) << FRAC_BITS);
  assign leak = div100(sum);
  assign diff = sum - SUM_BITS'(leak);
  assign acc_next_o = diff[ACC_BITS-1:0];

  // integer offset acc / (99 << frac), saturated to sample range
  assign quot = div99(acc_i[ACC_BITS-1:FRAC_BITS]);
  assign offset_o = (quot > Q99_BITS'(SAMPLE_MAX)) ? SAMPLE_MAX : quot[SAMPLE_BITS-1:0];

endmodule

### hdl/chgcal_fsm.sv
// ----------------------------------------------------------------------------
// chgcal_fsm: charger control state machine
// Phase, mode, timers, debounce counter and filter state, updated once per
// request taken from the input register.
// ----------------------------------------------------------------------------
module chgcal_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  chgcal_pkg::item_t   item_i,
  input  chgcal_pkg::cfg_t    cfg_i,
  output chgcal_pkg::res_t    res_o
);
  import chgcal_pkg::*;

  phase_e                 phase_q, phase_d;
  mode_e                  mode_q, mode_d;
  logic [CNT_BITS-1:0]    elapsed_q, elapsed_d;
  logic [CNT_BITS-1:0]    deb_q, deb_d;
  logic [ACC_BITS-1:0]    acc_q, acc_d;
  logic [SAMPLE_BITS-1:0] offset_q, offset_d;
  logic                   enable_q, enable_d;
  logic                   pulse;

  logic [ACC_BITS-1:0]    acc_step;
  logic [SAMPLE_BITS-1:0] offset_new;
  mode_e                  mode_op;
  logic [CNT_BITS-1:0]    elapsed_inc;
  logic [CNT_BITS-1:0]    deb_tmp;
  logic                   present;

  chgcal_filter u_filter (
    .acc_i      (acc_q),
    .raw_i      (item_i.current_raw),
    .acc_next_o (acc_step),
    .offset_o   (offset_new)
  );

  assign present     = item_i.charge_voltage >= cfg_i.threshold;
  assign elapsed_inc = sat_inc(elapsed_q);

  // operator action applied to mode first
  always_comb begin
    mode_op = mode_q;
    unique case (item_i.operation)
      OP_ACK:      mode_op = (mode_q == MODE_DET) ? MODE_ACK : mode_q;
      OP_WITHDRAW: mode_op = MODE_NONE;
      default:     mode_op = mode_q;
    endcase
  end

  // next state and result
  always_comb begin
    phase_d   = phase_q;
    mode_d    = mode_op;
    elapsed_d = elapsed_inc;
    deb_d     = deb_q;
    acc_d     = acc_q;
    offset_d  = offset_q;
    enable_d  = enable_q;
    pulse     = 1'b0;
    deb_tmp   = '0;
    unique case (phase_q)
      PH_WAIT_GOV: begin
        if (item_i.calibrate_request) begin
          acc_d     = '0;
          enable_d  = 1'b1;
          elapsed_d = '0;
          phase_d   = PH_CALIB;
        end
      end
      PH_CALIB: begin
        if (elapsed_inc > cfg_i.calib) begin
          offset_d  = offset_new;
          enable_d  = 1'b0;
          elapsed_d = '0;
          deb_d     = '0;
          phase_d   = PH_WAIT_CHG;
          pulse     = 1'b1;
        end else if (elapsed_inc > cfg_i.settle) begin
          acc_d = acc_step;
        end
      end
      PH_WAIT_CHG: begin
        if (elapsed_inc > cfg_i.period) begin
          elapsed_d = '0;
          deb_tmp   = present ? sat_inc(deb_q) : '0;
          deb_d     = deb_tmp;
          if (deb_tmp >= cfg_i.debounce) begin
            mode_d  = MODE_DET;
            deb_d   = '0;
            phase_d = PH_WAIT_ACK;
          end
        end
      end
      PH_WAIT_ACK: begin
        if (elapsed_inc > cfg_i.period) begin
          elapsed_d = '0;
          deb_tmp   = present ? '0 : sat_inc(deb_q);
          deb_d     = deb_tmp;
          if (deb_tmp >= cfg_i.debounce) begin
            mode_d = MODE_NONE;
          end
        end
        if (mode_d == MODE_ACK) begin
          enable_d  = 1'b1;
          elapsed_d = '0;
          phase_d   = PH_CHARGING;
        end else if (mode_d == MODE_NONE) begin
          deb_d     = '0;
          elapsed_d = '0;
          phase_d   = PH_WAIT_CHG;
        end
      end
      PH_CHARGING: begin
        if (mode_op != MODE_ACK) begin
          enable_d  = 1'b0;
          deb_d     = '0;
          elapsed_d = '0;
          phase_d   = PH_WAIT_CHG;
        end
      end
      default: begin
        enable_d = 1'b0;
        phase_d  = PH_WAIT_GOV;
      end
    endcase
  end

  // state registers, advance once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_INIT;
      mode_q    <= MODE_NONE;
      elapsed_q <= '0;
      deb_q     <= '0;
      acc_q     <= '0;
      offset_q  <= '0;
      enable_q  <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      elapsed_q <= elapsed_d;
      deb_q     <= deb_d;
      acc_q     <= acc_d;
      offset_q  <= offset_d;
      enable_q  <= enable_d;
    end
  end

  // values after the update
  assign res_o.charger_enable      = enable_d;
  assign res_o.phase               = phase_d;
  assign res_o.mode                = mode_d;
  assign res_o.current_offset      = offset_d;
  assign res_o.governor_init_pulse = pulse;

endmodule

### hdl/charger_detect_calibrate_fsm_core.sv
// ----------------------------------------------------------------------------
// charger_detect_calibrate_fsm_core: charger detect and calibrate controller
// Calibrates the charge current offset, debounces charger insertion and
// removal and drives the charger enable, one request per system tick.
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o  | calibrate_request, charge_voltage,
//            |                          | current_raw, operation
//   output   | out_valid_o / out_ready_i| charger_enable, phase, mode,
//            |                          | current_offset, governor_init_pulse
//   config   | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// The result is captured in the result register when its request leaves
// the input register; one request per cycle is sustained while out_ready_i
// is high, set by the combinational filter step in the state update.
// Reset clears the state machine and loads the config reset values; no
// clearing pass is needed. A stalled output holds the result register and
// the input register still takes one more request before in_ready_o drops.
// ----------------------------------------------------------------------------
module charger_detect_calibrate_fsm_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  calibrate_request_i,
  input  logic [chgcal_pkg::VOLT_BITS-1:0]      charge_voltage_i,
  input  logic [chgcal_pkg::SAMPLE_BITS-1:0]    current_raw_i,
  input  logic [chgcal_pkg::OP_BITS-1:0]        operation_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  charger_enable_o,
  output logic [2:0]                            phase_o,
  output logic [1:0]                            mode_o,
  output logic [chgcal_pkg::SAMPLE_BITS-1:0]    current_offset_o,
  output logic                                  governor_init_pulse_o,
  input  logic                                  cfg_we_i,
  input  logic [chgcal_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [chgcal_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);
  import chgcal_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  res, res_q;
  logic  out_valid_q;
  logic  out_free;
  logic  step;
  logic  in_take;

  chgcal_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  chgcal_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // pipeline handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.calibrate_request <= calibrate_request_i;
      item_q.charge_voltage    <= charge_voltage_i;
      item_q.current_raw       <= current_raw_i;
      item_q.operation         <= operation_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign charger_enable_o      = res_q.charger_enable;
  assign phase_o               = res_q.phase;
  assign mode_o                = res_q.mode;
  assign current_offset_o      = res_q.current_offset;
  assign governor_init_pulse_o = res_q.governor_init_pulse;

endmodule
